/* src/se2ti_pkg.sv */
// Shared types, constants and the arctangent lookup for the twist integrator.
package se2ti_pkg;

	localparam int FRAC_BITS = 16;
	localparam int RATE_W    = 32;
	localparam int ANG_W     = 19;
	localparam int THR_W     = 16;

	// angle reduction: |w| in Q(F+24), one conditional subtract of 2pi<<k per stage
	localparam int RED_SH    = 24;
	localparam int RED_W     = RATE_W + RED_SH;
	localparam int RED_STEPS = 13;
	localparam int RES_W     = 45;
	localparam int Z_SH      = FRAC_BITS - 6;

	localparam logic [63:0]      PI_Q60    = 64'h3243F6A8885A308D;
	localparam logic [RES_W-1:0] PI_QR     = RES_W'(PI_Q60 >> (36 - FRAC_BITS));
	localparam logic [RES_W-1:0] TWO_PI_QR = PI_QR << 1;

	// CORDIC datapath, Q30
	localparam int Q30_W = 34;
	localparam logic signed [Q30_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [Q30_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [Q30_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [Q30_W-1:0] ONE_Q30     = 34'sd1073741824;

	// translation: numerator Q(F+30), quotient Q30
	localparam int PROD_W   = 66;
	localparam int NUM_W    = 64;
	localparam int ROUND_SH = 30 - FRAC_BITS;

	typedef struct packed {
		logic                     bypass;
		logic signed [RATE_W-1:0] w;
		logic signed [RATE_W-1:0] vx;
		logic signed [RATE_W-1:0] vy;
	} twist_t;

	typedef struct packed {
		twist_t                  tw;
		logic signed [ANG_W-1:0] ang;
	} meta_t;

	typedef struct packed {
		logic signed [ANG_W-1:0]  pose_angle;
		logic signed [RATE_W-1:0] pose_x;
		logic signed [RATE_W-1:0] pose_y;
		logic                     saturated;
	} pose_t;

	function automatic logic signed [Q30_W-1:0] atan_q30(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'd843314856;
			1:  v = 32'd497837829;
			2:  v = 32'd263043836;
			3:  v = 32'd133525158;
			4:  v = 32'd67021686;
			5:  v = 32'd33543515;
			6:  v = 32'd16775850;
			7:  v = 32'd8388437;
			8:  v = 32'd4194282;
			9:  v = 32'd2097149;
			10: v = 32'd1048575;
			11: v = 32'd524287;
			12: v = 32'd262143;
			13: v = 32'd131071;
			14: v = 32'd65535;
			15: v = 32'd32767;
			16: v = 32'd16383;
			17: v = 32'd8191;
			18: v = 32'd4095;
			19: v = 32'd2047;
			20: v = 32'd1024;
			21: v = 32'd511;
			22: v = 32'd255;
			23: v = 32'd127;
			24: v = 32'd63;
			25: v = 32'd31;
			26: v = 32'd15;
			27: v = 32'd8;
			28: v = 32'd4;
			29: v = 32'd2;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return $signed(Q30_W'(v));
	endfunction

endpackage

/* src/se2ti_if.sv */
// Channel interfaces: twist input, pose output, threshold register write.
interface se2ti_twist_if;
	logic                             valid;
	logic                             ready;
	logic signed [se2ti_pkg::RATE_W-1:0] angular_rate;
	logic signed [se2ti_pkg::RATE_W-1:0] linear_rate_x;
	logic signed [se2ti_pkg::RATE_W-1:0] linear_rate_y;
	modport source (output valid, angular_rate, linear_rate_x, linear_rate_y, input ready);
	modport sink (input valid, angular_rate, linear_rate_x, linear_rate_y, output ready);
endinterface

interface se2ti_pose_if;
	logic                             valid;
	logic                             ready;
	logic signed [se2ti_pkg::ANG_W-1:0]  pose_angle;
	logic signed [se2ti_pkg::RATE_W-1:0] pose_x;
	logic signed [se2ti_pkg::RATE_W-1:0] pose_y;
	logic                             saturated;
	modport source (output valid, pose_angle, pose_x, pose_y, saturated, input ready);
	modport sink (input valid, pose_angle, pose_x, pose_y, saturated, output ready);
endinterface

interface se2ti_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [se2ti_pkg::THR_W-1:0]   zero_rate_threshold;
	modport source (output valid, zero_rate_threshold, input ready);
	modport sink (input valid, zero_rate_threshold, output ready);
endinterface

/* src/se2_twist_integrator_unit.sv */
// Top level of the SE(2) twist integrator: reduction, CORDIC, products, divide, output buffer.
//
// Usage:
//   twist (sink): angular_rate, linear_rate_x, linear_rate_y, signed Q16.16; one
//   transfer per accepted twist. pose (source): pose_angle (signed Q3.16, in (-pi, pi]),
//   pose_x, pose_y (Q16.16, clamped) and saturated; exactly one pose per twist, in order.
//   cfg (sink): zero_rate_threshold, always ready; write only while no twist is in flight.
//   A twist with |angular_rate| <= threshold yields angle 0 and the linear rates as-is.
// Pipeline:
//   From twist transfer to pose valid: 17 reduction stages, CORDIC_STEPS + 2 CORDIC
//   stages, 3 multiply/abs stages, 64 divider stages (one quotient bit each), 2 rounding
//   stages and the output buffer. Throughput is one twist per cycle while the output
//   buffer has a free entry.
// Stall:
//   The output is a two-entry buffer. The pipeline advances only while that buffer has
//   a free entry, so twist.ready is decoded from the buffer count register and drops
//   once both entries are held; nothing in flight is dropped or duplicated.
// Reset:
//   arst_n clears all valid bits, the buffer count and pointers and the threshold (to 0).
module se2_twist_integrator_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	se2ti_cfg_if.sink     cfg,
	se2ti_twist_if.sink   twist,
	se2ti_pose_if.source  pose
);

	localparam int RW = se2ti_pkg::RATE_W;
	localparam int PW = se2ti_pkg::PROD_W;
	localparam int NW = se2ti_pkg::NUM_W;
	localparam int QW = se2ti_pkg::Q30_W;
	localparam logic signed [PW-1:0] RND = PW'(1) << (se2ti_pkg::ROUND_SH - 1);
	localparam logic signed [RW-1:0] S32_MAX = {1'b0, {(RW-1){1'b1}}};
	localparam logic signed [RW-1:0] S32_MIN = {1'b1, {(RW-1){1'b0}}};

	logic en;

	// threshold register
	logic [se2ti_pkg::THR_W-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg.valid) begin
			thr_q <= cfg.zero_rate_threshold;
		end
	end

	// input
	se2ti_pkg::twist_t in_tw;
	logic [RW-1:0]     w_bits;
	logic [RW-1:0]     w_mag;

	assign w_bits = twist.angular_rate;
	assign w_mag  = w_bits[RW-1] ? (~w_bits + 1'b1) : w_bits;

	always_comb begin
		in_tw.bypass = (w_mag <= RW'(thr_q));
		in_tw.w      = twist.angular_rate;
		in_tw.vx     = twist.linear_rate_x;
		in_tw.vy     = twist.linear_rate_y;
	end

	assign twist.ready = en;

	logic                 red_valid;
	se2ti_pkg::meta_t     red_meta;
	logic signed [QW-1:0] red_z;

	se2ti_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (twist.valid),
		.in_tw     (in_tw),
		.out_valid (red_valid),
		.out_meta  (red_meta),
		.out_z     (red_z)
	);

	logic                 cor_valid;
	se2ti_pkg::meta_t     cor_meta;
	logic signed [QW-1:0] cor_cosm1;
	logic signed [QW-1:0] cor_sin;

	se2ti_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (red_valid),
		.in_meta   (red_meta),
		.in_z      (red_z),
		.out_valid (cor_valid),
		.out_meta  (cor_meta),
		.out_cosm1 (cor_cosm1),
		.out_sin   (cor_sin)
	);

	// products, numerator sums, sign/magnitude split
	logic                 v_s1, v_s2, v_s3;
	se2ti_pkg::meta_t     meta_s1, meta_s2, meta_s3;
	logic signed [PW-1:0] pxs_s1, pyc_s1, pys_s1, pxc_s1;
	logic signed [PW-1:0] nx_s2, ny_s2;
	logic [NW-1:0]        magx_s3, magy_s3;
	logic [1:0]           neg_s3;
	logic [RW-1:0]        den_s3;
	logic signed [PW-1:0] nx_abs, ny_abs;
	logic [RW-1:0]        w2_bits;

	assign nx_abs  = nx_s2[PW-1] ? -nx_s2 : nx_s2;
	assign ny_abs  = ny_s2[PW-1] ? -ny_s2 : ny_s2;
	assign w2_bits = meta_s2.tw.w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= cor_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= cor_meta;
			pxs_s1  <= cor_meta.tw.vx * cor_sin;
			pyc_s1  <= cor_meta.tw.vy * cor_cosm1;
			pys_s1  <= cor_meta.tw.vy * cor_sin;
			pxc_s1  <= cor_meta.tw.vx * cor_cosm1;
			meta_s2 <= meta_s1;
			nx_s2   <= pxs_s1 + pyc_s1;
			ny_s2   <= pys_s1 - pxc_s1;
			meta_s3 <= meta_s2;
			magx_s3 <= nx_abs[NW-1:0];
			magy_s3 <= ny_abs[NW-1:0];
			neg_s3  <= {ny_s2[PW-1] ^ w2_bits[RW-1], nx_s2[PW-1] ^ w2_bits[RW-1]};
			den_s3  <= w2_bits[RW-1] ? (~w2_bits + 1'b1) : w2_bits;
		end
	end

	logic                 div_valid;
	se2ti_pkg::meta_t     div_meta;
	logic [NW-1:0]        div_qx, div_qy;
	logic [1:0]           div_neg;

	se2ti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_meta   (meta_s3),
		.in_num_x  (magx_s3),
		.in_num_y  (magy_s3),
		.in_neg    (neg_s3),
		.in_den    (den_s3),
		.out_valid (div_valid),
		.out_meta  (div_meta),
		.out_quo_x (div_qx),
		.out_quo_y (div_qy),
		.out_neg   (div_neg)
	);

	// signed quotient, then round half up to Q(F)
	logic                 v_s4, v_s5;
	se2ti_pkg::meta_t     meta_s4, meta_s5;
	logic signed [PW-1:0] qx_s4, qy_s4;
	logic signed [PW-1:0] rx_s5, ry_s5;
	logic signed [PW-1:0] qx_mag, qy_mag;

	assign qx_mag = $signed({{(PW-NW){1'b0}}, div_qx});
	assign qy_mag = $signed({{(PW-NW){1'b0}}, div_qy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= div_meta;
			qx_s4   <= div_neg[0] ? -qx_mag : qx_mag;
			qy_s4   <= div_neg[1] ? -qy_mag : qy_mag;
			meta_s5 <= meta_s4;
			rx_s5   <= (qx_s4 + RND) >>> se2ti_pkg::ROUND_SH;
			ry_s5   <= (qy_s4 + RND) >>> se2ti_pkg::ROUND_SH;
		end
	end

	// clamp and zero-rotation select
	logic           hi_x, lo_x, hi_y, lo_y;
	se2ti_pkg::pose_t res;

	assign hi_x = !rx_s5[PW-1] && (rx_s5[PW-2:RW-1] != '0);
	assign lo_x =  rx_s5[PW-1] && (rx_s5[PW-2:RW-1] != '1);
	assign hi_y = !ry_s5[PW-1] && (ry_s5[PW-2:RW-1] != '0);
	assign lo_y =  ry_s5[PW-1] && (ry_s5[PW-2:RW-1] != '1);

	always_comb begin
		if (meta_s5.tw.bypass) begin
			res.pose_angle = '0;
			res.pose_x     = meta_s5.tw.vx;
			res.pose_y     = meta_s5.tw.vy;
			res.saturated  = 1'b0;
		end else begin
			res.pose_angle = meta_s5.ang;
			res.pose_x     = hi_x ? S32_MAX : (lo_x ? S32_MIN : rx_s5[RW-1:0]);
			res.pose_y     = hi_y ? S32_MAX : (lo_y ? S32_MIN : ry_s5[RW-1:0]);
			res.saturated  = hi_x || lo_x || hi_y || lo_y;
		end
	end

	// two-entry output buffer
	se2ti_pkg::pose_t buf_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign en   = (cnt_q != 2'd2);
	assign push = en && v_s5;
	assign pop  = pose.valid && pose.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign pose.valid      = (cnt_q != 2'd0);
	assign pose.pose_angle = buf_q[rd_ptr_q].pose_angle;
	assign pose.pose_x     = buf_q[rd_ptr_q].pose_x;
	assign pose.pose_y     = buf_q[rd_ptr_q].pose_y;
	assign pose.saturated  = buf_q[rd_ptr_q].saturated;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pose.ready) |=> (cnt_q == 2'd2 && !twist.ready))
		else $error("full buffer drained without a transfer");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid |-> (pose.pose_angle <= 19'sd205887 && pose.pose_angle >= -19'sd205887))
		else $error("pose angle outside (-pi, pi]");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && pose.saturated) |->
			(pose.pose_x == S32_MAX || pose.pose_x == S32_MIN ||
			 pose.pose_y == S32_MAX || pose.pose_y == S32_MIN))
		else $error("saturated flag without a clamped translation");
`endif

endmodule

/* src/se2ti_reduce.sv */
// Angle reduction pipeline: w mod 2pi into (-pi, pi], pose angle and CORDIC angle.
module se2ti_reduce (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  se2ti_pkg::twist_t                      in_tw,
	output logic                                   out_valid,
	output se2ti_pkg::meta_t                       out_meta,
	output logic signed [se2ti_pkg::Q30_W-1:0]     out_z
);

	localparam int N = se2ti_pkg::RED_STEPS;
	localparam int RW = se2ti_pkg::RES_W;
	localparam logic signed [RW-1:0] PI_S     = $signed(se2ti_pkg::PI_QR);
	localparam logic signed [RW-1:0] TWO_PI_S = $signed(se2ti_pkg::TWO_PI_QR);
	localparam logic signed [RW-1:0] ANG_RND  = RW'(1) << (se2ti_pkg::RED_SH - 1);
	localparam logic signed [RW-1:0] Z_RND    = RW'(1) << (se2ti_pkg::Z_SH - 1);

	logic [N:0]                       v_s;
	logic [N:0]                       neg_s;
	logic [se2ti_pkg::RED_W-1:0]      rem_s [N+1];
	se2ti_pkg::twist_t                tw_s [N+1];

	logic [se2ti_pkg::RATE_W-1:0] w_bits;
	logic [se2ti_pkg::RATE_W-1:0] w_mag;

	assign w_bits = in_tw.w;
	assign w_mag  = w_bits[se2ti_pkg::RATE_W-1] ? (~w_bits + 1'b1) : w_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tw_s[0]  <= in_tw;
			neg_s[0] <= w_bits[se2ti_pkg::RATE_W-1];
			rem_s[0] <= {w_mag, {se2ti_pkg::RED_SH{1'b0}}};
		end
	end

	// restoring reduction, quotient bit N-k decided in stage k
	for (genvar k = 1; k <= N; k++) begin : g_red
		localparam logic [se2ti_pkg::RED_W-1:0] SUB =
			se2ti_pkg::RED_W'(se2ti_pkg::TWO_PI_QR) << (N - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tw_s[k]  <= tw_s[k-1];
				neg_s[k] <= neg_s[k-1];
				rem_s[k] <= (rem_s[k-1] >= SUB) ? rem_s[k-1] - SUB : rem_s[k-1];
			end
		end
	end

	// sign restore, wrap into (-pi, pi], then rounding
	logic                     v_a_s, v_b_s;
	se2ti_pkg::twist_t        tw_a_s, tw_b_s;
	logic signed [RW-1:0]     r_a_s, r_b_s;
	logic signed [RW-1:0]     r_pos;
	logic signed [RW-1:0]     r_wrap;
	logic signed [RW-1:0]     ang_full;
	logic signed [RW-1:0]     z_full;

	assign r_pos = $signed(rem_s[N][RW-1:0]);

	always_comb begin
		if (r_a_s > PI_S) begin
			r_wrap = r_a_s - TWO_PI_S;
		end else if (r_a_s <= -PI_S) begin
			r_wrap = r_a_s + TWO_PI_S;
		end else begin
			r_wrap = r_a_s;
		end
	end

	assign ang_full = (r_b_s + ANG_RND) >>> se2ti_pkg::RED_SH;
	assign z_full   = (r_b_s + Z_RND) >>> se2ti_pkg::Z_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a_s     <= 1'b0;
			v_b_s     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_a_s     <= v_s[N];
			v_b_s     <= v_a_s;
			out_valid <= v_b_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tw_a_s       <= tw_s[N];
			r_a_s        <= neg_s[N] ? -r_pos : r_pos;
			tw_b_s       <= tw_a_s;
			r_b_s        <= r_wrap;
			out_meta.tw  <= tw_b_s;
			out_meta.ang <= ang_full[se2ti_pkg::ANG_W-1:0];
			out_z        <= z_full[se2ti_pkg::Q30_W-1:0];
		end
	end

endmodule

/* src/se2ti_cordic.sv */
// Rotation-mode CORDIC pipeline, one micro-rotation per stage; gives cos - 1 and sin in Q30.
module se2ti_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  se2ti_pkg::meta_t                       in_meta,
	input  logic signed [se2ti_pkg::Q30_W-1:0]     in_z,
	output logic                                   out_valid,
	output se2ti_pkg::meta_t                       out_meta,
	output logic signed [se2ti_pkg::Q30_W-1:0]     out_cosm1,
	output logic signed [se2ti_pkg::Q30_W-1:0]     out_sin
);

	localparam int QW = se2ti_pkg::Q30_W;

	logic [STEPS:0]             v_s;
	logic [STEPS:0]             neg_s;
	se2ti_pkg::meta_t           meta_s [STEPS+1];
	logic signed [QW-1:0]       x_s [STEPS+1];
	logic signed [QW-1:0]       y_s [STEPS+1];
	logic signed [QW-1:0]       z_s [STEPS+1];

	// fold into [-pi/2, pi/2]; the half turn is undone at the end by negation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= in_meta;
			x_s[0]    <= se2ti_pkg::GAIN_Q30;
			y_s[0]    <= '0;
			if (in_z > se2ti_pkg::HALF_PI_Q30) begin
				z_s[0]   <= in_z - se2ti_pkg::PI_Q30;
				neg_s[0] <= 1'b1;
			end else if (in_z < -se2ti_pkg::HALF_PI_Q30) begin
				z_s[0]   <= in_z + se2ti_pkg::PI_Q30;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= in_z;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		localparam logic signed [QW-1:0] ATAN = se2ti_pkg::atan_q30(k - 1);

		logic signed [QW-1:0] dx;
		logic signed [QW-1:0] dy;

		assign dx = y_s[k-1] >>> (k - 1);
		assign dy = x_s[k-1] >>> (k - 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= meta_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				if (!z_s[k-1][QW-1]) begin
					x_s[k] <= x_s[k-1] - dx;
					y_s[k] <= y_s[k-1] + dy;
					z_s[k] <= z_s[k-1] - ATAN;
				end else begin
					x_s[k] <= x_s[k-1] + dx;
					y_s[k] <= y_s[k-1] - dy;
					z_s[k] <= z_s[k-1] + ATAN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_meta  <= meta_s[STEPS];
			out_cosm1 <= (neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS]) - se2ti_pkg::ONE_Q30;
			out_sin   <= neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		end
	end

endmodule

/* src/se2ti_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module se2ti_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  se2ti_pkg::meta_t                   in_meta,
	input  logic [se2ti_pkg::NUM_W-1:0]        in_num_x,
	input  logic [se2ti_pkg::NUM_W-1:0]        in_num_y,
	input  logic [1:0]                         in_neg,
	input  logic [se2ti_pkg::RATE_W-1:0]       in_den,
	output logic                               out_valid,
	output se2ti_pkg::meta_t                   out_meta,
	output logic [se2ti_pkg::NUM_W-1:0]        out_quo_x,
	output logic [se2ti_pkg::NUM_W-1:0]        out_quo_y,
	output logic [1:0]                         out_neg
);

	localparam int NW = se2ti_pkg::NUM_W;
	localparam int DW = se2ti_pkg::RATE_W;

	logic [NW-1:0]        v_s;
	se2ti_pkg::meta_t     meta_s [NW];
	logic [1:0]           neg_s [NW];
	logic [DW-1:0]        den_s [NW];
	logic [DW-1:0]        rem_s [NW][2];
	logic [NW-1:0]        quo_s [NW][2];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic                 pv;
		se2ti_pkg::meta_t     pm;
		logic [1:0]           pn;
		logic [DW-1:0]        pd;
		logic [DW-1:0]        pr [2];
		logic [NW-1:0]        pq [2];

		if (k == 0) begin : g_first
			always_comb begin
				pv    = in_valid;
				pm    = in_meta;
				pn    = in_neg;
				pd    = in_den;
				pr[0] = '0;
				pr[1] = '0;
				pq[0] = in_num_x;
				pq[1] = in_num_y;
			end
		end else begin : g_next
			always_comb begin
				pv    = v_s[k-1];
				pm    = meta_s[k-1];
				pn    = neg_s[k-1];
				pd    = den_s[k-1];
				pr[0] = rem_s[k-1][0];
				pr[1] = rem_s[k-1][1];
				pq[0] = quo_s[k-1][0];
				pq[1] = quo_s[k-1][1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= pm;
				neg_s[k]  <= pn;
				den_s[k]  <= pd;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DW:0] r2;
			logic [DW:0] diff;
			logic        ge;

			// partial remainder stays below the divisor, so r2 < 2^DW and the borrow is exact
			assign r2   = {pr[l], pq[l][NW-1]};
			assign diff = r2 - {1'b0, pd};
			assign ge   = !diff[DW];

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? diff[DW-1:0] : r2[DW-1:0];
					quo_s[k][l] <= {pq[l][NW-2:0], ge};
				end
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign out_meta  = meta_s[NW-1];
	assign out_neg   = neg_s[NW-1];
	assign out_quo_x = quo_s[NW-1][0];
	assign out_quo_y = quo_s[NW-1][1];

endmodule

/* verif/tb_se2_twist_integrator_unit.sv */
// Self-checking testbench for the SE(2) twist integrator: directed and random twists vs. a predictor.
`timescale 1ns / 100ps

module tb_se2_twist_integrator_unit;

	localparam int  LATENCY   = 105;
	localparam int  NUM_STEPS = 16;
	localparam longint PI_FULL = 64'h3243F6A8885A308D;
	localparam longint PI_Q30_L  = 64'sd3373259426;
	localparam longint HALF_PI_L = 64'sd1686629713;
	localparam longint GAIN_L    = 64'sd652032874;
	localparam longint ONE_L     = 64'sd1073741824;
	localparam longint ATAN_TAB [0:15] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767};

	logic clk;
	logic arst_n;

	se2ti_cfg_if   cfg_ch();
	se2ti_twist_if twist_ch();
	se2ti_pose_if  pose_ch();

	se2_twist_integrator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.twist  (twist_ch),
		.pose   (pose_ch)
	);

	se2ti_pkg::pose_t pending_poses[$];
	logic [15:0] threshold_model;
	int          error_count;
	int          poses_seen;
	int          twists_sent;
	int          hold_off_cycles;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** se2_twist_integrator_unit: FAILED **");
		$finish;
	end

	function automatic longint round_down_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_rate(longint v, ref bit clipped);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic se2ti_pkg::pose_t predict_pose(logic signed [31:0] w_in,
			logic signed [31:0] vx_in, logic signed [31:0] vy_in);
		longint w, vx, vy, mag, pi_q, two_pi, r, a, cx, cy, z, dx, dy, cm1, nx, ny;
		longint px, py, ang;
		bit     flip, clipped;
		se2ti_pkg::pose_t p;
		w = w_in;
		vx = vx_in;
		vy = vy_in;
		mag = (w < 0) ? -w : w;
		clipped = 1'b0;
		ang = 0;
		if (mag <= longint'(threshold_model)) begin
			px = vx;
			py = vy;
		end else begin
			pi_q = PI_FULL >>> (36 - se2ti_pkg::FRAC_BITS);
			two_pi = 2 * pi_q;
			r = (w * (longint'(1) <<< 24)) % two_pi;
			if (r > pi_q)
				r -= two_pi;
			else if (r <= -pi_q)
				r += two_pi;
			ang = round_down_shift(r, 24);
			a = round_down_shift(r, se2ti_pkg::FRAC_BITS - 6);
			flip = 1'b0;
			if (a > HALF_PI_L) begin
				a -= PI_Q30_L;
				flip = 1'b1;
			end else if (a < -HALF_PI_L) begin
				a += PI_Q30_L;
				flip = 1'b1;
			end
			cx = GAIN_L;
			cy = 0;
			z = a;
			for (int i = 0; i < NUM_STEPS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (z >= 0) begin
					cx -= dx;
					cy += dy;
					z -= ATAN_TAB[i];
				end else begin
					cx += dx;
					cy -= dy;
					z += ATAN_TAB[i];
				end
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			cm1 = cx - ONE_L;
			nx = vx * cy + vy * cm1;
			ny = vy * cy - vx * cm1;
			px = clamp_rate(round_down_shift(nx / w, 30 - se2ti_pkg::FRAC_BITS), clipped);
			py = clamp_rate(round_down_shift(ny / w, 30 - se2ti_pkg::FRAC_BITS), clipped);
		end
		p.pose_angle = ang[se2ti_pkg::ANG_W-1:0];
		p.pose_x = px[31:0];
		p.pose_y = py[31:0];
		p.saturated = clipped;
		return p;
	endfunction

	// one twist transfer; inputs change on the falling edge
	task automatic send_twist(logic signed [31:0] w, logic signed [31:0] vx,
			logic signed [31:0] vy);
		while (!no_idle && $urandom_range(99) < 30) begin
			twist_ch.valid = 1'b0;
			@(negedge clk);
		end
		twist_ch.valid = 1'b1;
		twist_ch.angular_rate = w;
		twist_ch.linear_rate_x = vx;
		twist_ch.linear_rate_y = vy;
		do @(posedge clk); while (!twist_ch.ready);
		pending_poses.push_back(predict_pose(w, vx, vy));
		twists_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		twist_ch.valid = 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(logic [15:0] value);
		drain_pipeline();
		cfg_ch.valid = 1'b1;
		cfg_ch.zero_rate_threshold = value;
		do @(posedge clk); while (!cfg_ch.ready);
		threshold_model = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic signed [31:0] random_rate(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed(32'($urandom_range(70000))) * ($urandom_range(1) ? 1 : -1);
			2: return 32'sd205887 * $signed(32'($urandom_range(20))) - 32'sd102944
				+ $signed(32'($urandom_range(64))) - 32'sd32;
			default: return $signed(32'($urandom_range(2000000))) - 32'sd1000000;
		endcase
	endfunction

	task automatic test_directed_edges();
		logic signed [31:0] lim[5];
		lim = '{32'sh80000000, 32'sh7FFFFFFF, 32'sd0, -32'sd1, 32'sd65536};
		write_threshold(16'd0);
		foreach (lim[i])
			send_twist(lim[i], lim[(i + 1) % 5], lim[(i + 3) % 5]);
		// angle exactly at +/- pi and near the CORDIC quadrant fold
		send_twist(32'sd205887, 32'sd65536, -32'sd65536);
		send_twist(-32'sd205887, 32'sd65536, 32'sd65536);
		send_twist(32'sd102944, 32'sd1000, 32'sd2000);
		send_twist(-32'sd102943, -32'sd1000, 32'sd2000);
		// tiny rotation with huge linear rates -> clamp
		send_twist(32'sd1, 32'sh7FFFFFFF, 32'sh80000000);
		send_twist(-32'sd1, 32'sh80000000, 32'sh7FFFFFFF);
		write_threshold(16'd1000);
		send_twist(32'sd1000, 32'sd12345, -32'sd54321);
		send_twist(-32'sd1000, 32'sd12345, -32'sd54321);
		send_twist(32'sd1001, 32'sd12345, -32'sd54321);
		send_twist(-32'sd1001, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		write_threshold(16'hFFFF);
		send_twist(32'sd65535, 32'sh80000000, 32'sh7FFFFFFF);
		send_twist(-32'sd65535, 32'sd7, 32'sd9);
		send_twist(32'sd65536, 32'sd65536, 32'sd65536);
		send_twist(-32'sd65536, -32'sd65536, 32'sd65536);
	endtask

	task automatic test_random_twists(int count, logic [15:0] thr);
		int kind;
		write_threshold(thr);
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(3);
			send_twist(random_rate(kind), random_rate($urandom_range(1) ? 0 : 3),
				random_rate($urandom_range(1) ? 0 : 3));
		end
	endtask

	task automatic test_no_idle_burst(int count);
		no_idle = 1'b1;
		test_random_twists(count, 16'($urandom));
		no_idle = 1'b0;
	endtask

	// receiver holds off long enough that the output buffer fills and input stalls
	task automatic test_output_backpressure();
		write_threshold(16'd0);
		hold_off_cycles = 400;
		no_idle = 1'b1;
		for (int n = 0; n < 150; n++)
			send_twist($urandom, random_rate(3), random_rate(3));
		no_idle = 1'b0;
	endtask

	// pose sink: sample at rising edge, change ready at falling edge
	initial begin
		se2ti_pkg::pose_t want;
		pose_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pose_ch.valid && pose_ch.ready) begin
				poses_seen++;
				if (pending_poses.size() == 0) begin
					$error("pose transfer with no twist outstanding");
					error_count++;
				end else begin
					want = pending_poses.pop_front();
					if (pose_ch.pose_angle !== want.pose_angle) begin
						$error("pose_angle expected %0d got %0d", want.pose_angle,
							pose_ch.pose_angle);
						error_count++;
					end
					if (pose_ch.pose_x !== want.pose_x) begin
						$error("pose_x expected %0d got %0d", want.pose_x, pose_ch.pose_x);
						error_count++;
					end
					if (pose_ch.pose_y !== want.pose_y) begin
						$error("pose_y expected %0d got %0d", want.pose_y, pose_ch.pose_y);
						error_count++;
					end
					if (pose_ch.saturated !== want.saturated) begin
						$error("saturated expected %0b got %0b", want.saturated,
							pose_ch.saturated);
						error_count++;
					end
				end
			end
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				pose_ch.ready = 1'b0;
			end else begin
				pose_ch.ready = no_idle || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin
		int wait_cycles;
		error_count = 0;
		poses_seen = 0;
		twists_sent = 0;
		hold_off_cycles = 0;
		no_idle = 1'b0;
		threshold_model = 16'd0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.zero_rate_threshold = '0;
		twist_ch.valid = 1'b0;
		twist_ch.angular_rate = '0;
		twist_ch.linear_rate_x = '0;
		twist_ch.linear_rate_y = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_random_twists(250, 16'd0);
		test_random_twists(200, 16'hFFFF);
		test_output_backpressure();
		test_no_idle_burst(100);
		test_random_twists(100, 16'($urandom));

		twist_ch.valid = 1'b0;
		wait_cycles = 0;
		while (pending_poses.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_poses.size() != 0) begin
			$error("%0d poses never arrived", pending_poses.size());
			error_count++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		$display("Sent %0d twists over several thresholds incl. 0 and 0xFFFF, %0d poses checked,",
			twists_sent, poses_seen);
		$display("with random idling, an idle-free burst and a long output hold-off.");
		if (error_count == 0)
			$display("** se2_twist_integrator_unit: PASSED **");
		else
			$display("** se2_twist_integrator_unit: FAILED **");
		$finish;
	end

endmodule

/* files.f */
src/se2ti_pkg.sv
src/se2ti_if.sv
src/se2ti_reduce.sv
src/se2ti_cordic.sv
src/se2ti_div.sv
src/se2_twist_integrator_unit.sv
verif/tb_se2_twist_integrator_unit.sv
